@@ rtl/msc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, field widths and the seven-segment code table for the
// multiplexed seven-segment scanner.
// ----------------------------------------------------------------------------
package msc_pkg;

   // fixed payload widths
   localparam int unsigned ValueWidth   = 32;
   localparam int unsigned LineWidth    = 3;
   localparam int unsigned SegWidth     = 7;
   localparam int unsigned BcdDigitBits = 4;

   // scanner control states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } msc_state_type;

   // segment pattern of one decimal digit, bit i drives segment i
   function automatic logic [SegWidth-1:0] seg_code(input logic [BcdDigitBits-1:0] digit);
      logic [SegWidth-1:0] code;
      case (digit)
         4'd0:    code = 7'h77;
         4'd1:    code = 7'h24;
         4'd2:    code = 7'h5D;
         4'd3:    code = 7'h6D;
         4'd4:    code = 7'h2E;
         4'd5:    code = 7'h6B;
         4'd6:    code = 7'h7B;
         4'd7:    code = 7'h25;
         4'd8:    code = 7'h7F;
         4'd9:    code = 7'h6F;
         default: code = '0;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/msc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_req_if
// Scan tick channel: valid/ready handshake carrying the number to display.
// ----------------------------------------------------------------------------
interface msc_req_if;
   logic                            valid;
   logic                            ready;
   logic [msc_pkg::ValueWidth-1:0]  shown_value;

   modport source (output valid, output shown_value, input ready);
   modport sink   (input valid, input shown_value, output ready);
endinterface

@@ rtl/msc_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_rsp_if
// Result channel: valid/ready handshake carrying line index and segments.
// ----------------------------------------------------------------------------
interface msc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [msc_pkg::LineWidth-1:0]  line_select;
   logic [msc_pkg::SegWidth-1:0]   segment_drive;

   modport source (output valid, output line_select, output segment_drive, input ready);
   modport sink   (input valid, input line_select, input segment_drive, output ready);
endinterface

@@ rtl/msc_bcd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_bcd
// Bit-serial binary to BCD converter (shift and add-3), one input bit per
// cycle; keeps only the low DIGIT_COUNT decimal digits.
// ----------------------------------------------------------------------------
module msc_bcd #(
   parameter int unsigned DIGIT_COUNT = 5
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [msc_pkg::ValueWidth-1:0]                value,
   output logic                                          done,
   output logic [DIGIT_COUNT*msc_pkg::BcdDigitBits-1:0]  digits
);

   localparam int unsigned BcdWidth = DIGIT_COUNT * msc_pkg::BcdDigitBits;
   localparam int unsigned CountW   = $clog2(msc_pkg::ValueWidth);

   logic [msc_pkg::ValueWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]            bcd_ff, bcd_in;
   logic [CountW-1:0]              count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [BcdWidth-1:0]            adjusted;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (bcd_ff[k*msc_pkg::BcdDigitBits +: msc_pkg::BcdDigitBits] >= 4'd5) begin
            adjusted[k*msc_pkg::BcdDigitBits +: msc_pkg::BcdDigitBits] =
               bcd_ff[k*msc_pkg::BcdDigitBits +: msc_pkg::BcdDigitBits] + 4'd3;
         end else begin
            adjusted[k*msc_pkg::BcdDigitBits +: msc_pkg::BcdDigitBits] =
               bcd_ff[k*msc_pkg::BcdDigitBits +: msc_pkg::BcdDigitBits];
         end
      end
   end

   // sequencing: load, then one shift per cycle
   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bin_in   = value;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // digits shifted out of the top are dropped: value mod 10^DIGIT_COUNT
         bcd_in   = {adjusted[BcdWidth-2:0], bin_ff[msc_pkg::ValueWidth-1]};
         bin_in   = {bin_ff[msc_pkg::ValueWidth-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CountW'(msc_pkg::ValueWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // payload shift registers
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

@@ rtl/multiplexed_seven_segment_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner
// Scans a multiplexed seven-segment display: each tick steps the line index
// and returns that line's segment pattern; a frame start converts the value.
// ----------------------------------------------------------------------------
//  channel    direction  handshake      payload
//  req_chan   in         valid/ready    shown_value[31:0]
//  rsp_chan   out        valid/ready    line_select[2:0], segment_drive[6:0]
//  csr_*      in         write enable   csr_wr_data (display_enable)
//
// A tick that wraps the line index to 0 first runs the bit-serial BCD
// converter on its value and then hands off; other ticks go straight to hand-off.
// Ticks while disabled are taken and give no item.
// Synchronous reset clears line index, enable and the frame-loaded flag.
// A held result register lets the next tick be taken while a result waits.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner #(
   parameter int unsigned LINE_COUNT  = 6,
   parameter int unsigned DIGIT_COUNT = 5
) (
   input  logic        clock,
   input  logic        reset,
   msc_req_if.sink     req_chan,
   msc_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int unsigned IdxW     = $clog2(LINE_COUNT);
   localparam int unsigned BcdWidth = DIGIT_COUNT * msc_pkg::BcdDigitBits;

   msc_pkg::msc_state_type          state_ff, state_in;
   logic [IdxW-1:0]                 idx_ff, idx_in;
   logic                            enable_ff;
   logic                            filled_ff, filled_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [msc_pkg::LineWidth-1:0]   line_ff;
   logic [msc_pkg::SegWidth-1:0]    seg_ff, seg_value;
   logic                            load_rsp;
   logic                            conv_start;
   logic                            conv_done;
   logic                            accept;
   logic [BcdWidth-1:0]             digits;
   logic [msc_pkg::BcdDigitBits-1:0] line_digit;
   logic                            line_has_digit;

   // serial decimal conversion of the frame value
   msc_bcd #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (req_chan.shown_value),
      .done   (conv_done),
      .digits (digits)
   );

   assign req_chan.ready = (state_ff == msc_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // digit for the current line, most significant digit on line 0
   always_comb begin
      line_digit     = '0;
      line_has_digit = 1'b0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (int'(idx_ff) == k) begin
            line_digit     = digits[(DIGIT_COUNT-1-k)*msc_pkg::BcdDigitBits +:
                                    msc_pkg::BcdDigitBits];
            line_has_digit = 1'b1;
         end
      end
      seg_value = (filled_ff && line_has_digit) ? msc_pkg::seg_code(line_digit) : '0;
   end

   // tick sequencing
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      filled_in  = filled_ff;
      conv_start = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         msc_pkg::ST_IDLE: begin
            if (accept && enable_ff) begin
               if (idx_ff == IdxW'(LINE_COUNT - 1)) begin
                  idx_in     = '0;
                  conv_start = 1'b1;
                  filled_in  = 1'b1;
                  state_in   = msc_pkg::ST_CONV;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = msc_pkg::ST_EMIT;
               end
            end
         end
         msc_pkg::ST_CONV: begin
            if (conv_done) begin
               state_in = msc_pkg::ST_EMIT;
            end
         end
         msc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = msc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msc_pkg::ST_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msc_pkg::ST_IDLE;
         idx_ff       <= '0;
         enable_ff    <= 1'b0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         line_ff <= msc_pkg::LineWidth'(idx_ff);
         seg_ff  <= seg_value;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.line_select   = line_ff;
   assign rsp_chan.segment_drive = seg_ff;

endmodule

@@ verif/tb_multiplexed_seven_segment_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiplexed_seven_segment_scanner
// Self-checking bench for the display scanner. A queue-fed driver sends scan
// ticks and works out the expected line and segment item of each enabled one. A
// monitor compares every returned item with the oldest expectation. The run
// toggles the display enable while idle, and goes through idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_multiplexed_seven_segment_scanner;

   localparam int unsigned Lines       = 6;
   localparam int unsigned Digits      = 5;
   localparam int unsigned DrainCycles = 60;
   localparam int unsigned PhaseTicks  = 310;

   // segment code of each decimal digit, bit i drives segment i
   localparam logic [msc_pkg::SegWidth-1:0] DigitSegments [10] = '{
      7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
   };

   typedef struct {
      logic [msc_pkg::LineWidth-1:0] line;
      logic [msc_pkg::SegWidth-1:0]  segments;
   } scan_item_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   msc_req_if req_bus ();
   msc_rsp_if rsp_bus ();

   multiplexed_seven_segment_scanner dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // scanner state as the bench sees it
   logic                          display_on;
   logic [msc_pkg::LineWidth-1:0] scan_line;
   logic [msc_pkg::SegWidth-1:0]  line_patterns [Lines];

   logic [msc_pkg::ValueWidth-1:0] pending_ticks [$];
   scan_item_type                  expected_scans [$];

   int mismatch_count     = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // step the line and refill the patterns at frame start
   task automatic predict_tick(input logic [msc_pkg::ValueWidth-1:0] value);
      logic [msc_pkg::ValueWidth-1:0] rest;
      scan_item_type                  item;
      if (!display_on) return;
      scan_line = (scan_line == Lines - 1) ? '0 : scan_line + 1'b1;
      if (scan_line == 0) begin
         rest = value;
         foreach (line_patterns[i]) line_patterns[i] = '0;
         for (int k = Digits - 1; k >= 0; k--) begin
            line_patterns[k] = DigitSegments[rest % 10];
            rest = rest / 10;
         end
      end
      item.line     = scan_line;
      item.segments = line_patterns[scan_line];
      expected_scans.push_back(item);
   endtask

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_tick(req_bus.shown_value);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_bus.valid       <= 1'b1;
               req_bus.shown_value <= pending_ticks.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : scan_monitor
      scan_item_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_scans.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item, expected none, actual line %0d segments %02h",
                        $time, rsp_bus.line_select, rsp_bus.segment_drive);
            end else begin
               want = expected_scans.pop_front();
               if (rsp_bus.line_select !== want.line) begin
                  mismatch_count++;
                  $display("%0t: line_select expected %0d actual %0d",
                           $time, want.line, rsp_bus.line_select);
               end
               if (rsp_bus.segment_drive !== want.segments) begin
                  mismatch_count++;
                  $display("%0t: segment_drive expected %02h actual %02h",
                           $time, want.segments, rsp_bus.segment_drive);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // block until every tick is taken and every item has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_bus.valid || expected_scans.size() != 0);
   endtask

   // enable write, only once the scanner has gone quiet
   task automatic set_display(input logic on);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      display_on = on;
   endtask

   function automatic logic [msc_pkg::ValueWidth-1:0] random_value();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return $urandom_range(0, 99999);
         2:       return $urandom_range(0, 9);
         3:       return 32'hFFFF_FFFF - $urandom_range(0, 200);
         default: return {4'($urandom_range(0, 9)), 28'h0} | $urandom_range(0, 255);
      endcase
   endfunction

   task automatic push_ticks(input int count);
      repeat (count) pending_ticks.push_back(random_value());
   endtask

   initial begin : stimulus
      int counted;
      int seg_len;
      logic seg_on;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.shown_value = '0;
      rsp_bus.ready       = 1'b0;
      reset               = 1'b1;
      display_on          = 1'b0;
      scan_line           = '0;
      foreach (line_patterns[i]) line_patterns[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ticks while dark give nothing
      push_ticks(2);
      // first frame: lines 1 to 5 blank, then the wrap loads the all-ones value
      set_display(1'b1);
      push_ticks(5);
      pending_ticks.push_back(32'hFFFF_FFFF);
      push_ticks(3);
      // disable mid frame, then resume from the same line
      set_display(1'b0);
      push_ticks(2);
      set_display(1'b1);
      push_ticks(2);
      pending_ticks.push_back(32'd31048);
      // all zero digits
      push_ticks(5);
      pending_ticks.push_back(32'd0);

      // random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         sender_idle_pct    = (phase == 1) ? 85 : (phase == 3) ? 27 : 0;
         receiver_stall_pct = (phase == 2) ? 85 : (phase == 3) ? 27 : 0;
         counted = 0;
         while (counted < PhaseTicks) begin
            seg_on  = ($urandom_range(0, 4) != 0);
            seg_len = seg_on ? $urandom_range(20, 80) : $urandom_range(3, 10);
            if (seg_on != display_on) set_display(seg_on);
            push_ticks(seg_len);
            if (seg_on) counted += seg_len;
         end
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/msc_pkg.sv
rtl/msc_req_if.sv
rtl/msc_rsp_if.sv
rtl/msc_bcd.sv
rtl/multiplexed_seven_segment_scanner.sv
verif/tb_multiplexed_seven_segment_scanner.sv
